// File: rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// Single-wire bus master package
// Shared payload types, command codes, register indexes and register reset
// values for the single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  // Width of every timing register
  localparam int CfgW = 10;
  // Width of the register index
  localparam int CfgIdxW = 3;

  // Command codes carried by each tick
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_RELEASE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_ZERO_LOW = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_TOTAL    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_READ_LOW      = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE   = 3'd7;

  // Register reset values in microseconds
  localparam logic [CfgW-1:0] DEF_RESET_LOW      = 10'd480;
  localparam logic [CfgW-1:0] DEF_PRESENCE_WAIT  = 10'd70;
  localparam logic [CfgW-1:0] DEF_RESET_RELEASE  = 10'd410;
  localparam logic [CfgW-1:0] DEF_WRITE_ONE_LOW  = 10'd2;
  localparam logic [CfgW-1:0] DEF_WRITE_ZERO_LOW = 10'd60;
  localparam logic [CfgW-1:0] DEF_SLOT_TOTAL     = 10'd62;
  localparam logic [CfgW-1:0] DEF_READ_LOW       = 10'd2;
  localparam logic [CfgW-1:0] DEF_READ_SAMPLE    = 10'd12;

  // Timing register set
  typedef struct packed {
    logic [CfgW-1:0] reset_low_us;
    logic [CfgW-1:0] presence_wait_us;
    logic [CfgW-1:0] reset_release_us;
    logic [CfgW-1:0] write_one_low_us;
    logic [CfgW-1:0] write_zero_low_us;
    logic [CfgW-1:0] slot_total_us;
    logic [CfgW-1:0] read_low_us;
    logic [CfgW-1:0] read_sample_us;
  } cfg_regs_t;

  // One tick item
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       line_level;
  } tick_in_t;

  // One tick result
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] byte_read;
  } tick_out_t;

endpackage

// File: rtl/owbm_cfg.sv
// ----------------------------------------------------------------------------
// Single-wire bus master timing registers
// Holds the eight timing registers and decodes writes from the register port.
// ----------------------------------------------------------------------------
module owbm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]        cfg_addr_i,
  input  logic [owbm_pkg::CfgW-1:0]           cfg_wdata_i,
  output owbm_pkg::cfg_regs_t                 regs_o
);

  owbm_pkg::cfg_regs_t regs_q;

  // Register file with decoded single-register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.reset_low_us      <= owbm_pkg::DEF_RESET_LOW;
      regs_q.presence_wait_us  <= owbm_pkg::DEF_PRESENCE_WAIT;
      regs_q.reset_release_us  <= owbm_pkg::DEF_RESET_RELEASE;
      regs_q.write_one_low_us  <= owbm_pkg::DEF_WRITE_ONE_LOW;
      regs_q.write_zero_low_us <= owbm_pkg::DEF_WRITE_ZERO_LOW;
      regs_q.slot_total_us     <= owbm_pkg::DEF_SLOT_TOTAL;
      regs_q.read_low_us       <= owbm_pkg::DEF_READ_LOW;
      regs_q.read_sample_us    <= owbm_pkg::DEF_READ_SAMPLE;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        owbm_pkg::CFG_RESET_LOW:      regs_q.reset_low_us      <= cfg_wdata_i;
        owbm_pkg::CFG_PRESENCE_WAIT:  regs_q.presence_wait_us  <= cfg_wdata_i;
        owbm_pkg::CFG_RESET_RELEASE:  regs_q.reset_release_us  <= cfg_wdata_i;
        owbm_pkg::CFG_WRITE_ONE_LOW:  regs_q.write_one_low_us  <= cfg_wdata_i;
        owbm_pkg::CFG_WRITE_ZERO_LOW: regs_q.write_zero_low_us <= cfg_wdata_i;
        owbm_pkg::CFG_SLOT_TOTAL:     regs_q.slot_total_us     <= cfg_wdata_i;
        owbm_pkg::CFG_READ_LOW:       regs_q.read_low_us       <= cfg_wdata_i;
        owbm_pkg::CFG_READ_SAMPLE:    regs_q.read_sample_us    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

// File: rtl/owbm_core.sv
// ----------------------------------------------------------------------------
// Single-wire bus master sequencer
// Holds the operation state and works out one tick: line drive, status and
// the next state. The state advances only when a tick is committed.
// ----------------------------------------------------------------------------
module owbm_core #(
  parameter int TimerBits = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  owbm_pkg::tick_in_t   item_i,
  input  owbm_pkg::cfg_regs_t  cfg_i,
  output owbm_pkg::tick_out_t  res_o
);

  // One bit more than the timer so that the length cap itself fits.
  localparam int LenW = TimerBits + 1;

  // Phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_WAIT = 3'd2;
  localparam logic [2:0] PH_RST_REC  = 3'd3;
  localparam logic [2:0] PH_WRITE    = 3'd4;
  localparam logic [2:0] PH_READ     = 3'd5;

  typedef logic [LenW-1:0] len_t;

  // A zero length counts as one tick; lengths are capped at the timer range.
  function automatic len_t lim_len(logic [owbm_pkg::CfgW-1:0] x);
    len_t v;
    len_t cap;
    v   = len_t'(x);
    cap = len_t'(1) << TimerBits;
    if (x == '0) begin
      v = len_t'(1);
    end else if (v > cap) begin
      v = cap;
    end
    return v;
  endfunction

  logic [2:0]           phase_q, phase_d;
  logic [TimerBits-1:0] tick_q, tick_d;
  logic [2:0]           bit_q, bit_d;
  logic [7:0]           shift_q, shift_d;
  logic                 pres_q, pres_d;
  logic [7:0]           tx_q, tx_d;

  len_t len_rst_low, len_pres, len_rec, len_w1, len_w0, len_slot, len_rlow;
  len_t samp_raw, samp_at;
  len_t tc_ext, tc_inc;
  logic drive, busy, done, wbit;

  // Effective lengths and the read sample point.
  always_comb begin
    len_rst_low = lim_len(cfg_i.reset_low_us);
    len_pres    = lim_len(cfg_i.presence_wait_us);
    len_rec     = lim_len(cfg_i.reset_release_us);
    len_w1      = lim_len(cfg_i.write_one_low_us);
    len_w0      = lim_len(cfg_i.write_zero_low_us);
    len_slot    = lim_len(cfg_i.slot_total_us);
    len_rlow    = lim_len(cfg_i.read_low_us);
    // A zero sample offset samples on the first tick of the slot.
    samp_raw    = (cfg_i.read_sample_us == '0) ? '0 : lim_len(cfg_i.read_sample_us);
    samp_at     = (samp_raw > len_slot - len_t'(1)) ? len_slot - len_t'(1) : samp_raw;
  end

  // One tick of the sequencer.
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    tx_d    = tx_q;
    drive   = 1'b0;
    busy    = 1'b0;
    done    = 1'b0;
    wbit    = 1'b0;

    // An idle tick may start a command, and is then its first tick.
    if (phase_q == PH_IDLE) begin
      tick_d = '0;
      bit_d  = '0;
      case (item_i.action)
        owbm_pkg::ACT_RESET: phase_d = PH_RST_LOW;
        owbm_pkg::ACT_WRITE: begin
          phase_d = PH_WRITE;
          tx_d    = item_i.data_byte;
        end
        owbm_pkg::ACT_READ: begin
          phase_d = PH_READ;
          shift_d = '0;
        end
        default: begin
        end
      endcase
    end

    tc_ext = len_t'(tick_d);
    tc_inc = tc_ext + len_t'(1);

    case (phase_d)
      PH_RST_LOW: begin
        busy  = 1'b1;
        drive = 1'b1;
        if (tc_inc >= len_rst_low) begin
          phase_d = PH_RST_WAIT;
          tick_d  = '0;
        end else begin
          tick_d = tc_inc[TimerBits-1:0];
        end
      end
      PH_RST_WAIT: begin
        busy = 1'b1;
        if (tc_inc >= len_pres) begin
          phase_d = PH_RST_REC;
          tick_d  = '0;
        end else begin
          tick_d = tc_inc[TimerBits-1:0];
        end
      end
      PH_RST_REC: begin
        busy = 1'b1;
        // The first recovery tick samples the presence answer.
        if (tick_d == '0) begin
          pres_d = ~item_i.line_level;
        end
        if (tc_inc >= len_rec) begin
          phase_d = PH_IDLE;
          tick_d  = '0;
          done    = 1'b1;
        end else begin
          tick_d = tc_inc[TimerBits-1:0];
        end
      end
      PH_WRITE, PH_READ: begin
        busy = 1'b1;
        if (phase_d == PH_WRITE) begin
          wbit  = tx_d[bit_d];
          drive = tc_ext < (wbit ? len_w1 : len_w0);
        end else begin
          drive = tc_ext < len_rlow;
          // Sampled bits enter from the top, so the byte fills LSB first.
          if (tc_ext == samp_at) begin
            shift_d = {item_i.line_level, shift_d[7:1]};
          end
        end
        if (tc_inc >= len_slot) begin
          tick_d = '0;
          if (&bit_d) begin
            phase_d = PH_IDLE;
            bit_d   = '0;
            done    = 1'b1;
          end else begin
            bit_d = bit_d + 3'd1;
          end
        end else begin
          tick_d = tc_inc[TimerBits-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // State commits only on a tick that produces a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
      tx_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      tx_q    <= tx_d;
    end
  end

  assign res_o.drive_low = drive;
  assign res_o.busy_res  = busy;
  assign res_o.done_res  = done;
  assign res_o.presence  = pres_d;
  assign res_o.byte_read = shift_d;

endmodule

// File: rtl/onewire_bus_master_core.sv
// ----------------------------------------------------------------------------
// Single-wire bus master
// Top level: tick input register, sequencer, timing registers and the
// result register.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one microsecond tick carrying the
// sampled line level and, when idle, an optional command (bus reset, byte
// write, byte read); each tick yields exactly one result transfer with the
// line drive, busy, done, presence flag and read byte. The block takes one
// tick per clock cycle while results are taken: a tick is held in the input
// register, worked out by the sequencer and its result is captured in the
// result register, from which it is offered. The input keeps flowing as long as
// the result register is free or is emptied in the same cycle; a stalled
// result holds the tick behind it, and that in turn holds the input. The user
// must write timing registers through the register port only while no
// operation runs; the block does not enforce this. A length of zero counts as
// one tick and lengths are capped at 2**TimerBits ticks.
module onewire_bus_master_core #(
  parameter int TimerBits = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  owbm_pkg::tick_in_t            in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output owbm_pkg::tick_out_t           out_o,
  input  logic                          cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [owbm_pkg::CfgW-1:0]     cfg_wdata_i
);

  owbm_pkg::tick_in_t  in_q;
  logic                in_vld_q;
  owbm_pkg::tick_out_t out_q, res;
  logic                out_vld_q;
  owbm_pkg::cfg_regs_t regs;
  logic                advance;

  // A held tick moves on once the result register is free or being emptied.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  owbm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .regs_o      (regs)
  );

  owbm_core #(
    .TimerBits (TimerBits)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (regs),
    .res_o  (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  // A finishing tick always belongs to a running operation.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.done_res |-> out_o.busy_res)
    else $error("done result outside an operation");

  // The line is only pulled low while an operation runs.
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.drive_low |-> out_o.busy_res)
    else $error("line driven while idle");

  // A tick that advances always leaves a result behind.
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced tick produced no result");
`endif

endmodule
